// File: hdl/gn3_pkg.sv
// Shared types and constants of the 3D gradient noise block.
// No dependencies; every other file of the block but gn3_ram imports this package.
package gn3_pkg;

  localparam int COORD_W     = 32;
  localparam int TABLE_AW    = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int NOISE_W     = 18;
  localparam int NOISE_MAX   = 131071;
  localparam int NOISE_MIN   = -131072;
  localparam int INQ_DEPTH   = 4;
  localparam int OUTQ_DEPTH  = 32;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  typedef struct packed {
    func_e                      func;
    logic [TABLE_AW-1:0]        table_index;
    logic [TABLE_AW-1:0]        table_value;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } item_t;

endpackage

// File: hdl/gradient_noise_3d.sv
// Top level of the improved 3D gradient noise block.
// Depends on gn3_pkg, gn3_front, gn3_core, gn3_outq and gn3_ram.
//
// The block takes one transaction per clock cycle while full is low and returns one noise
// value per clock cycle for steady evaluations that are popped. A load transaction
// writes one byte of the 256-entry permutation table and gives no result; the table
// must be fully loaded before the first evaluate transaction, since entries are not
// cleared at reset and no clearing pass runs. An evaluate transaction takes signed
// fixed-point x, y and z with FRAC_BITS fraction bits and yields a signed value with
// FRAC_BITS fraction bits, saturated to 18 bits. With nothing backed up, the transaction
// is written into the input queue at the accepting edge and issued in the next cycle,
// then passes seventeen register stages of the back-end pipeline (three table lookups
// in series, four multiplications of the fade curve and three interpolation levels)
// and one in the result queue, where the result becomes visible. The fourteen table
// reads per point are served by seven copies of the table, each with two read ports;
// a load updates each copy as it passes the stage that reads that copy, so loads and
// evaluations keep their order. Up to 32 evaluations may be in flight or waiting in
// the result queue; once that many are outstanding, further evaluate transactions
// wait in the 4-entry input queue until results are popped, and full rises when that
// queue fills.
module gradient_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                func_i,
  input  logic [7:0]          table_index_i,
  input  logic [7:0]          table_value_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  output logic                empty,
  input  logic                pop,
  output logic signed [17:0]  noise_value_o
);
  import gn3_pkg::*;

  localparam int RW = $clog2(OUTQ_DEPTH + 1);

  item_t                     fe_item;
  logic                      fe_valid;
  logic                      issue;
  logic                      is_eval;
  logic                      pop_ok;
  logic                      res_valid;
  logic signed [NOISE_W-1:0] res_value;

  // Count of evaluations issued to the back end whose results are not yet popped.
  logic [RW-1:0] resv_q, resv_d;

  gn3_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (func_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .valid_o       (fe_valid),
    .item_o        (fe_item),
    .take_i        (issue)
  );

  // Loads always go through; an evaluation needs a free slot in the result queue.
  assign is_eval = (fe_item.func == FUNC_EVAL);
  assign issue   = fe_valid && (!is_eval || (resv_q < RW'(OUTQ_DEPTH)));
  assign pop_ok  = pop && !empty;

  gn3_core #(.FRAC_BITS(FRAC_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .item_i      (fe_item),
    .res_valid_o (res_valid),
    .res_value_o (res_value)
  );

  gn3_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_value),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (noise_value_o)
  );

  assign resv_d = resv_q + RW'(issue && is_eval) - RW'(pop_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resv_q <= '0;
    end else begin
      resv_q <= resv_d;
    end
  end

  // The reservation count never exceeds the result queue's depth.
  a_resv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resv_q <= RW'(OUTQ_DEPTH))
    else $error("result reservations exceed the result queue depth");

  // With nothing reserved, no result can be waiting.
  a_resv_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (resv_q == '0) |-> empty)
    else $error("result present with no reservation");

  // A full input queue always has a transaction at its head.
  a_full_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> fe_valid)
    else $error("input queue full but head not valid");

endmodule

// File: hdl/gn3_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hdl/gn3_front.sv
// Front end: accepts input transactions, classifies them and queues them.
// Depends on gn3_pkg.
module gn3_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                func_i,
  input  logic [gn3_pkg::TABLE_AW-1:0]        table_index_i,
  input  logic [gn3_pkg::TABLE_AW-1:0]        table_value_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]  coord_z_i,
  output logic                                valid_o,
  output gn3_pkg::item_t                      item_o,
  input  logic                                take_i
);
  import gn3_pkg::*;

  localparam int PTR_W = $clog2(INQ_DEPTH);

  item_t            mem_q [INQ_DEPTH];
  item_t            item_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             push_ok, pop_ok;

  assign full    = (count_q == (PTR_W+1)'(INQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign push_ok = push && !full;
  assign pop_ok  = take_i && valid_o;

  always_comb begin
    item_d.func        = func_i ? FUNC_EVAL : FUNC_LOAD;
    item_d.table_index = table_index_i;
    item_d.table_value = table_value_i;
    item_d.coord_x     = coord_x_i;
    item_d.coord_y     = coord_y_i;
    item_d.coord_z     = coord_z_i;
    wr_ptr_d = push_ok ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (PTR_W+1)'(push_ok) - (PTR_W+1)'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= item_d;
    end
  end

endmodule

// File: hdl/gn3_core.sv
// Back end: table hashing, fade curves, gradients and trilinear interpolation.
// Depends on gn3_pkg and gn3_ram.
module gn3_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_i,
  input  gn3_pkg::item_t                      item_i,
  output logic                                res_valid_o,
  output logic signed [gn3_pkg::NOISE_W-1:0]  res_value_o
);
  import gn3_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int TA  = TABLE_AW;
  localparam int AW  = F + 5;
  localparam int PW  = AW + F + 1;
  localparam int CW  = F + 2;
  localparam int VW  = F + 3;
  localparam int DW  = F + 4;
  localparam int MW  = AW + DW;
  localparam int SW  = (DW > NOISE_W) ? DW : NOISE_W;
  localparam int NST = 17;

  localparam logic signed [PW-1:0] HALF_P = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [MW-1:0] HALF_M = {{(MW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [AW-1:0] TEN_ONE     = {5'd10, {F{1'b0}}};
  localparam logic signed [AW-1:0] FIFTEEN_ONE = {5'd15, {F{1'b0}}};
  localparam logic signed [CW-1:0] ONE_C       = {2'b01, {F{1'b0}}};
  localparam logic signed [SW-1:0] SAT_HI      = SW'(NOISE_MAX);
  localparam logic signed [SW-1:0] SAT_LO      = SW'(NOISE_MIN);

  function automatic logic signed [PW-1:0] fmul(logic signed [AW-1:0] a, logic [F-1:0] t);
    logic signed [F:0] ts;
    ts = $signed({1'b0, t});
    return a * ts;
  endfunction

  function automatic logic signed [AW-1:0] frnd(logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + HALF_P;
    return AW'(s >>> F);
  endfunction

  function automatic logic signed [MW-1:0] lmul(logic signed [AW-1:0] f,
                                                logic signed [DW-1:0] d);
    return f * d;
  endfunction

  function automatic logic signed [DW-1:0] lrnd(logic signed [MW-1:0] p);
    logic signed [MW-1:0] s;
    s = p + HALF_M;
    return DW'(s >>> F);
  endfunction

  // Control chains.
  logic [NST-1:0] ev_q, ev_d;
  logic [2:0]     ld_q, ld_d;

  // Payload riding along the stages.
  logic [TA-1:0]           idx_q [3];
  logic [TA-1:0]           val_q [3];
  logic [TA-1:0]           cell_q [3][3];
  logic [F-1:0]            t_q [7][3];
  logic signed [AW-1:0]    fa_q [3], fa_d [3];
  logic signed [PW-1:0]    fp1_q [3], fp2_q [3], fp3_q [3], fp4_q [3];
  logic signed [AW-1:0]    fb_q [3], fc_q [3], fd_q [3], fade_q [3];
  logic signed [AW-1:0]    fdl_q [6][3];
  logic signed [VW-1:0]    g_q [4][8], g_d [8];
  logic signed [VW-1:0]    lo1_q [2][4], lo1_d [4];
  logic signed [DW-1:0]    diff1_q [4], diff1_d [4];
  logic signed [MW-1:0]    prod1_q [4];
  logic signed [VW-1:0]    m_q [4], m_d [4];
  logic signed [VW-1:0]    lo2_q [2][2];
  logic signed [DW-1:0]    diff2_q [2], diff2_d [2];
  logic signed [MW-1:0]    prod2_q [2];
  logic signed [VW-1:0]    n_q [2], n_d [2];
  logic signed [VW-1:0]    lo3_q [2];
  logic signed [DW-1:0]    diff3_q, diff3_d;
  logic signed [MW-1:0]    prod3_q;
  logic signed [NOISE_W-1:0] res_q, res_d;

  logic signed [COORD_W-1:0] coord_in [3];
  logic [F-1:0]              t_in [3];
  logic [TA-1:0]             cell_in [3];

  // Table copies: one for the x lookups, two for the y level, four for z.
  logic [TA-1:0] r1_rd [2];
  logic [TA-1:0] r2_rd [2][2];
  logic [TA-1:0] r3_rd [4][2];

  gn3_ram #(.WIDTH(TA), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk_i     (clk_i),
    .we_i      (ld_q[0]),
    .waddr_i   (idx_q[0]),
    .wdata_i   (val_q[0]),
    .raddr_a_i (cell_q[0][0]),
    .raddr_b_i (cell_q[0][0] + TA'(1)),
    .rdata_a_o (r1_rd[0]),
    .rdata_b_o (r1_rd[1])
  );

  for (genvar n = 0; n < 2; n++) begin : g_ram_y
    logic [TA-1:0] base;
    assign base = r1_rd[n] + cell_q[1][1];
    gn3_ram #(.WIDTH(TA), .DEPTH(TABLE_DEPTH)) u_ram (
      .clk_i     (clk_i),
      .we_i      (ld_q[1]),
      .waddr_i   (idx_q[1]),
      .wdata_i   (val_q[1]),
      .raddr_a_i (base),
      .raddr_b_i (base + TA'(1)),
      .rdata_a_o (r2_rd[n][0]),
      .rdata_b_o (r2_rd[n][1])
    );
  end

  // Instance n serves the corners with x offset n[0] and y offset n[1].
  for (genvar n = 0; n < 4; n++) begin : g_ram_z
    logic [TA-1:0] base;
    assign base = r2_rd[n % 2][n / 2] + cell_q[2][2];
    gn3_ram #(.WIDTH(TA), .DEPTH(TABLE_DEPTH)) u_ram (
      .clk_i     (clk_i),
      .we_i      (ld_q[2]),
      .waddr_i   (idx_q[2]),
      .wdata_i   (val_q[2]),
      .raddr_a_i (base),
      .raddr_b_i (base + TA'(1)),
      .rdata_a_o (r3_rd[n][0]),
      .rdata_b_o (r3_rd[n][1])
    );
  end

  assign coord_in[0] = item_i.coord_x;
  assign coord_in[1] = item_i.coord_y;
  assign coord_in[2] = item_i.coord_z;

  always_comb begin
    ev_d = {ev_q[NST-2:0], issue_i && (item_i.func == FUNC_EVAL)};
    ld_d = {ld_q[1:0], issue_i && (item_i.func == FUNC_LOAD)};
    for (int i = 0; i < 3; i++) begin
      t_in[i]    = coord_in[i][F-1:0];
      cell_in[i] = coord_in[i][F+TA-1:F];
      fa_d[i]    = $signed({3'b000, t_in[i], 2'b00}) + $signed({4'b0000, t_in[i], 1'b0})
                   - FIFTEEN_ONE;
    end
  end

  // Gradients of the eight corners; corner bit 0 is x, bit 1 is y, bit 2 is z.
  always_comb begin
    logic [3:0]           h;
    logic [2:0]           cb;
    logic [TA-1:0]        hash;
    logic signed [CW-1:0] pc [3];
    logic signed [CW-1:0] u, v;
    logic signed [VW-1:0] uu, vv;
    for (int c = 0; c < 8; c++) begin
      cb   = 3'(c);
      hash = r3_rd[cb[1:0]][cb[2]];
      h    = hash[3:0];
      for (int a = 0; a < 3; a++) begin
        pc[a] = $signed({2'b00, t_q[3][a]}) - (cb[a] ? ONE_C : '0);
      end
      u = (h < 4'd8) ? pc[0] : pc[1];
      if (h < 4'd4) begin
        v = pc[1];
      end else if (h inside {4'd12, 4'd14}) begin
        v = pc[0];
      end else begin
        v = pc[2];
      end
      uu = VW'(u);
      vv = VW'(v);
      g_d[c] = (h[0] ? -uu : uu) + (h[1] ? -vv : vv);
    end
  end

  always_comb begin
    logic signed [DW-1:0] sum;
    logic signed [SW-1:0] ext;
    for (int j = 0; j < 4; j++) begin
      lo1_d[j]   = g_q[3][2*j];
      diff1_d[j] = DW'(g_q[3][2*j+1]) - DW'(g_q[3][2*j]);
      sum        = DW'(lo1_q[1][j]) + lrnd(prod1_q[j]);
      m_d[j]     = sum[VW-1:0];
    end
    for (int k = 0; k < 2; k++) begin
      diff2_d[k] = DW'(m_q[2*k+1]) - DW'(m_q[2*k]);
      sum        = DW'(lo2_q[1][k]) + lrnd(prod2_q[k]);
      n_d[k]     = sum[VW-1:0];
    end
    diff3_d = DW'(n_q[1]) - DW'(n_q[0]);
    sum     = DW'(lo3_q[1]) + lrnd(prod3_q);
    ext     = SW'(sum);
    if (ext > SAT_HI) begin
      res_d = NOISE_W'(SAT_HI);
    end else if (ext < SAT_LO) begin
      res_d = NOISE_W'(SAT_LO);
    end else begin
      res_d = ext[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= '0;
      ld_q <= '0;
    end else begin
      ev_q <= ev_d;
      ld_q <= ld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q[0] <= item_i.table_index;
    val_q[0] <= item_i.table_value;
    for (int s = 1; s < 3; s++) begin
      idx_q[s]  <= idx_q[s-1];
      val_q[s]  <= val_q[s-1];
      cell_q[s] <= cell_q[s-1];
    end
    for (int s = 1; s < 7; s++) begin
      t_q[s] <= t_q[s-1];
    end
    for (int i = 0; i < 3; i++) begin
      cell_q[0][i] <= cell_in[i];
      t_q[0][i]    <= t_in[i];
      fa_q[i]      <= fa_d[i];
      fp1_q[i]     <= fmul(fa_q[i], t_q[0][i]);
      fb_q[i]      <= frnd(fp1_q[i]) + TEN_ONE;
      fp2_q[i]     <= fmul(fb_q[i], t_q[2][i]);
      fc_q[i]      <= frnd(fp2_q[i]);
      fp3_q[i]     <= fmul(fc_q[i], t_q[4][i]);
      fd_q[i]      <= frnd(fp3_q[i]);
      fp4_q[i]     <= fmul(fd_q[i], t_q[6][i]);
      fade_q[i]    <= frnd(fp4_q[i]);
    end
    fdl_q[0] <= fade_q;
    for (int s = 1; s < 6; s++) begin
      fdl_q[s] <= fdl_q[s-1];
    end
    g_q[0] <= g_d;
    for (int s = 1; s < 4; s++) begin
      g_q[s] <= g_q[s-1];
    end
    lo1_q[0] <= lo1_d;
    lo1_q[1] <= lo1_q[0];
    diff1_q  <= diff1_d;
    for (int j = 0; j < 4; j++) begin
      prod1_q[j] <= lmul(fade_q[0], diff1_q[j]);
    end
    m_q <= m_d;
    for (int k = 0; k < 2; k++) begin
      lo2_q[0][k] <= m_q[2*k];
      prod2_q[k]  <= lmul(fdl_q[2][1], diff2_q[k]);
    end
    lo2_q[1] <= lo2_q[0];
    diff2_q  <= diff2_d;
    n_q      <= n_d;
    lo3_q[0] <= n_q[0];
    lo3_q[1] <= lo3_q[0];
    diff3_q  <= diff3_d;
    prod3_q  <= lmul(fdl_q[5][2], diff3_q);
    res_q    <= res_d;
  end

  assign res_valid_o = ev_q[NST-1];
  assign res_value_o = res_q;

endmodule

// File: hdl/gn3_outq.sv
// Result queue between the back end and the result port.
// Depends on gn3_pkg.
module gn3_outq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [gn3_pkg::NOISE_W-1:0]  data_i,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic signed [gn3_pkg::NOISE_W-1:0]  data_o
);
  import gn3_pkg::*;

  localparam int PTR_W = $clog2(OUTQ_DEPTH);

  logic signed [NOISE_W-1:0] mem_q [OUTQ_DEPTH];
  logic [PTR_W-1:0]          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]            count_q, count_d;
  logic                      pop_ok;

  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_ok ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the gradient_noise_3d block.
// Depends on gn3_pkg and gradient_noise_3d; holds its own noise predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gn3_pkg::*;

  localparam int FRAC = 16;
  localparam int END_WAIT = 40;

  typedef enum int {
    NOISE_OK,
    NOISE_UNEXPECTED,
    NOISE_WRONG
  } noise_check_e;

  // The scoreboard keeps a private copy of the permutation table. It turns
  // every accepted transaction into the noise value the block should return.
  class noise_scoreboard;
    logic [7:0] perm_copy [TABLE_DEPTH];
    logic signed [NOISE_W-1:0] noise_queue [$];
    int unsigned loads_seen;
    int unsigned evals_seen;
    int unsigned results_seen;

    function longint round_shift(longint p);
      return (p + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function longint fade(longint t);
      longint one;
      longint a;
      longint b;
      longint c;
      longint d;
      one = longint'(1) << FRAC;
      a = 6 * t - 15 * one;
      b = round_shift(a * t) + 10 * one;
      c = round_shift(b * t);
      d = round_shift(c * t);
      return round_shift(d * t);
    endfunction

    function longint blend(longint t, longint a, longint b);
      return a + round_shift(t * (b - a));
    endfunction

    function longint grad(int unsigned hash, longint x, longint y, longint z);
      int unsigned h;
      longint u;
      longint v;
      h = hash & 15;
      u = (h < 8) ? x : y;
      v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
      return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function int unsigned perm(int unsigned i);
      return perm_copy[i & 255];
    endfunction

    function logic signed [NOISE_W-1:0] noise_at(logic [31:0] px, logic [31:0] py,
                                                 logic [31:0] pz);
      int unsigned cx, cy, cz, a, aa, ab, b, ba, bb;
      longint x, y, z, u, v, w, one, r;
      cx = (px >> FRAC) & 255;
      cy = (py >> FRAC) & 255;
      cz = (pz >> FRAC) & 255;
      x = px & ((32'd1 << FRAC) - 1);
      y = py & ((32'd1 << FRAC) - 1);
      z = pz & ((32'd1 << FRAC) - 1);
      one = longint'(1) << FRAC;
      u = fade(x);
      v = fade(y);
      w = fade(z);
      a = perm(cx) + cy;
      aa = perm(a) + cz;
      ab = perm(a + 1) + cz;
      b = perm(cx + 1) + cy;
      ba = perm(b) + cz;
      bb = perm(b + 1) + cz;
      r = blend(w,
            blend(v,
              blend(u, grad(perm(aa), x, y, z), grad(perm(ba), x - one, y, z)),
              blend(u, grad(perm(ab), x, y - one, z),
                       grad(perm(bb), x - one, y - one, z))),
            blend(v,
              blend(u, grad(perm(aa + 1), x, y, z - one),
                       grad(perm(ba + 1), x - one, y, z - one)),
              blend(u, grad(perm(ab + 1), x, y - one, z - one),
                       grad(perm(bb + 1), x - one, y - one, z - one))));
      if (r > NOISE_MAX) r = NOISE_MAX;
      if (r < NOISE_MIN) r = NOISE_MIN;
      return r[NOISE_W-1:0];
    endfunction

    function void note_item(logic func, logic [7:0] idx, logic [7:0] val,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (func == FUNC_LOAD) begin
        perm_copy[idx] = val;
        loads_seen++;
      end else begin
        noise_queue.push_back(noise_at(x, y, z));
        evals_seen++;
      end
    endfunction

    function noise_check_e check_noise(logic signed [NOISE_W-1:0] got,
                                       output logic signed [NOISE_W-1:0] want);
      want = 'x;
      if (noise_queue.size() == 0) return NOISE_UNEXPECTED;
      want = noise_queue.pop_front();
      results_seen++;
      return (got === want) ? NOISE_OK : NOISE_WRONG;
    endfunction

    function int pending();
      return noise_queue.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  logic                func;
  logic [7:0]          table_index;
  logic [7:0]          table_value;
  logic signed [31:0]  coord_x;
  logic signed [31:0]  coord_y;
  logic signed [31:0]  coord_z;
  logic                empty;
  logic                pop;
  logic signed [17:0]  noise_value;

  noise_scoreboard sb = new();
  int  error_count = 0;
  bit  idle_on = 1'b1;     // random idling on both sides while set
  bit  hold_request = 1'b0; // asks the receiver for one long hold-off
  bit  hold_done = 1'b0;

  gradient_noise_3d #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push         (push),
    .full         (full),
    .func_i       (func),
    .table_index_i(table_index),
    .table_value_i(table_value),
    .coord_x_i    (coord_x),
    .coord_y_i    (coord_y),
    .coord_z_i    (coord_z),
    .empty        (empty),
    .pop          (pop),
    .noise_value_o(noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Prints one line per error and keeps the tally for the final verdict.
  task automatic report(string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  // Both handshakes are sampled at the clock edge, before the block and the
  // drivers update anything, so the order of events inside a step is irrelevant.
  always @(posedge clk) begin
    logic signed [NOISE_W-1:0] want;
    noise_check_e status;
    if (rst_n) begin
      if (push && !full)
        sb.note_item(func, table_index, table_value, coord_x, coord_y, coord_z);
      if (pop && !empty) begin
        status = sb.check_noise(noise_value, want);
        if (status == NOISE_UNEXPECTED)
          report($sformatf("noise value %0d with no transaction outstanding",
                           noise_value));
        else if (status == NOISE_WRONG)
          report($sformatf("noise value %0d, expected %0d", noise_value, want));
      end
    end
  end

  // Receiver: pops in random bursts, and once holds off for a long stretch so
  // that the result queue fills and the input side backs up.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        for (hold_left = 300; hold_left > 0; hold_left--) begin
          pop <= 1'b0;
          @(posedge clk);
        end
        hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offers one transaction and returns once it has been accepted. Push stays
  // high into the next transaction unless an idle burst is drawn.
  task automatic send(logic f, logic [7:0] idx, logic [7:0] val,
                      logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push        <= 1'b1;
    func        <= f;
    table_index <= idx;
    table_value <= val;
    coord_x     <= x;
    coord_y     <= y;
    coord_z     <= z;
    do @(posedge clk); while (full);
  endtask

  task automatic send_eval(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send(FUNC_EVAL, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  // Sender pauses until every outstanding noise value has come back, then
  // allows the pipeline time to settle on any trailing loads.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
  endtask

  // Loads the whole table: a shuffled permutation, or plain random bytes.
  task automatic load_table(bit shuffled);
    logic [7:0] vals [TABLE_DEPTH];
    logic [7:0] tmp;
    int j;
    for (int i = 0; i < TABLE_DEPTH; i++) vals[i] = shuffled ? i[7:0] : 8'($urandom);
    if (shuffled) begin
      for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = vals[i];
        vals[i] = vals[j];
        vals[j] = tmp;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++)
      send(FUNC_LOAD, i[7:0], vals[i], $urandom, $urandom, $urandom);
  endtask

  // Random coordinates: full-range patterns, some near cell borders,
  // some with fractions pinned to zero or to their largest value.
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    c = $urandom;
    case ($urandom_range(0, 5))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hffff;
      2: c[15:0] = 16'($urandom_range(0, 3));
      3: c[23:16] = 8'hff;
      default: ;
    endcase
    return c;
  endfunction

  task automatic random_block(int count, int load_pct);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < load_pct)
        send(FUNC_LOAD, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
      else
        send_eval(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    func        = FUNC_LOAD;
    table_index = '0;
    table_value = '0;
    coord_x     = '0;
    coord_y     = '0;
    coord_z     = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every entry is written before the first evaluation.
    load_table(1'b1);

    // Directed points: origin, extremes of the coordinate range, fractions at
    // their limits, and cells that wrap the table index.
    send_eval(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_eval(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_eval(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_eval(32'h0000_ffff, 32'h0000_8000, 32'h0000_0001);
    send_eval(32'h00ff_0000, 32'h00ff_ffff, 32'h00ff_8000);
    send_eval(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_eval(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_eval(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    send_eval(32'hffff_0000, 32'h0000_ffff, 32'hff00_8000);
    send_eval(32'h0000_4000, 32'h0000_c000, 32'hffff_4000);
    send(FUNC_LOAD, 8'd0, 8'd255, '0, '0, '0);
    send(FUNC_LOAD, 8'd255, 8'd0, '0, '0, '0);
    send_eval(32'h00ff_ffff, 32'h0000_0000, 32'h00ff_0000);
    send_eval(32'h0000_0000, 32'h00ff_ffff, 32'hffff_ffff);

    random_block(250, 8);

    // The receiver stalls for a long time while the sender keeps pushing.
    hold_request = 1'b1;
    random_block(120, 0);
    while (!hold_done) @(posedge clk);
    random_block(400, 8);

    // Fresh table of arbitrary bytes, not a permutation.
    drain();
    load_table(1'b0);
    random_block(400, 10);

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    random_block(250, 5);

    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (sb.pending() > 0)
      report($sformatf("%0d noise values never arrived", sb.pending()));

    $display("Run covered %0d table loads and %0d evaluations; %0d noise values checked.",
             sb.loads_seen, sb.evals_seen, sb.results_seen);
    $display("Two full table fills, a long result stall and a drained pause were included.");
    if (error_count == 0)
      $display("gradient_noise_3d verification clean");
    else
      $display("gradient_noise_3d verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d noise values outstanding.", sb.pending());
    $display("gradient_noise_3d verification failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/gn3_pkg.sv
hdl/gn3_ram.sv
hdl/gn3_front.sv
hdl/gn3_core.sv
hdl/gn3_outq.sv
hdl/gradient_noise_3d.sv
sim/testbench.sv
